/* sv/abec_pkg.sv */
// ----------------------------------------------------------------------------
// abec_pkg
// Shared types, constants and helpers of the boomerang entry counter.
// ----------------------------------------------------------------------------
package abec_pkg;

  localparam int WORD_BITS  = 16;
  localparam int FIELD_BITS = 16;
  localparam int LIMIT_BITS = 16;
  localparam int CNT_BITS   = 33;
  localparam int WIDE_BITS  = LIMIT_BITS + WORD_BITS;

  typedef logic [WORD_BITS-1:0]  word_t;
  typedef logic [FIELD_BITS-1:0] field_t;
  typedef logic [LIMIT_BITS-1:0] limit_t;
  typedef logic [CNT_BITS-1:0]   cnt_t;
  typedef logic [WIDE_BITS-1:0]  wide_t;

  typedef struct packed {
    field_t alpha;
    field_t alpha_prime;
    field_t beta;
    field_t beta_prime;
  } quartet_t;

  typedef struct packed {
    cnt_t match_count;
    cnt_t pair_count;
  } result_t;

  typedef struct packed {
    word_t alpha;
    word_t alpha_prime;
    word_t beta;
    word_t beta_prime;
  } diff_t;

  typedef struct packed {
    logic  valid;
    logic  last;
    word_t x;
    word_t y;
    diff_t diff;
  } issue_t;

  typedef struct packed {
    logic valid;
    logic last;
    logic hit;
  } eval_t;

  typedef struct packed {
    logic start;
    logic load;
  } ctrl_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_DRAIN,
    S_DONE
  } state_e;

  // Zero or out-of-range limit selects the full word range.
  function automatic word_t eff_limit(limit_t lim);
    wide_t w;
    wide_t m;
    w = wide_t'(lim);
    m = wide_t'({WORD_BITS{1'b1}});
    if (w == '0 || w > m) begin
      return '1;
    end
    return word_t'(w);
  endfunction

endpackage

/* sv/arx_boomerang_entry_counter_unit.sv */
// ----------------------------------------------------------------------------
// arx_boomerang_entry_counter_unit
// Counts boomerang solutions of one modular-addition quartet over x, y.
// ----------------------------------------------------------------------------
// Operation: the sweep issues every x, y pair up to the effective limit
//   (full word range when the register holds 0), then drains into the result.
// Flow: the shared pair unit tests one x, y pair per cycle; a new quartet is
//   taken only once the finished result waits in the output register.
// Reset: asynchronous, active low; idle, limit register 0, no result pending.
module arx_boomerang_entry_counter_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  abec_pkg::limit_t   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  abec_pkg::quartet_t in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output abec_pkg::result_t  out_data_o
);

  abec_pkg::limit_t  limit_q;
  abec_pkg::issue_t  issue;
  abec_pkg::eval_t   eval;
  abec_pkg::ctrl_t   ctrl;
  abec_pkg::cnt_t    match_q;
  abec_pkg::cnt_t    pairs_q;
  abec_pkg::result_t out_q;
  logic              out_valid_q;
  logic              out_free;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  abec_sweep_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .limit_i    (limit_q),
    .out_free_i (out_free),
    .eval_i     (eval),
    .issue_o    (issue),
    .ctrl_o     (ctrl)
  );

  abec_pair_eval u_eval (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .eval_o  (eval)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.start) begin
      match_q <= '0;
      pairs_q <= '0;
    end else if (eval.valid) begin
      match_q <= match_q + abec_pkg::cnt_t'(eval.hit);
      pairs_q <= pairs_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      out_q <= '{match_count: match_q, pair_count: pairs_q};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_load_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.load |-> !eval.valid)
    else $error("result loaded while pairs still in flight");

  a_start_when_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.start |-> !eval.valid && !ctrl.load)
    else $error("new sweep started during evaluation");

  a_result_pairs_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> (out_q.pair_count != '0))
    else $error("result with empty pair count");

endmodule

/* sv/abec_pair_eval.sv */
// ----------------------------------------------------------------------------
// abec_pair_eval
// Shared evaluation unit: tests one x, y pair per cycle, registered result.
// ----------------------------------------------------------------------------
module abec_pair_eval (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  abec_pkg::issue_t issue_i,
  output abec_pkg::eval_t  eval_o
);

  abec_pkg::word_t u;
  abec_pkg::word_t v;
  logic            hit;
  logic            valid_q;
  logic            last_q;
  logic            hit_q;

  always_comb begin
    u = ((issue_i.x + issue_i.y) ^ issue_i.diff.beta)
        - (issue_i.y ^ issue_i.diff.beta_prime);
    v = (((issue_i.x ^ issue_i.diff.alpha) + (issue_i.y ^ issue_i.diff.alpha_prime))
         ^ issue_i.diff.beta)
        - (issue_i.y ^ issue_i.diff.alpha_prime ^ issue_i.diff.beta_prime);
    hit = ((u ^ v) == issue_i.diff.alpha);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      last_q  <= 1'b0;
    end else begin
      valid_q <= issue_i.valid;
      last_q  <= issue_i.valid & issue_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q <= hit;
  end

  assign eval_o = '{valid: valid_q, last: last_q, hit: hit_q};

  a_valid_follows_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_i.valid |=> valid_q)
    else $error("evaluation result lost");

  a_last_implies_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> valid_q)
    else $error("last flag without valid result");

  a_no_spurious_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !issue_i.valid |=> !valid_q)
    else $error("result without issued pair");

endmodule

/* sv/abec_sweep_ctrl.sv */
// ----------------------------------------------------------------------------
// abec_sweep_ctrl
// Sequencer: holds the quartet and walks x, y over 0..effective limit into the unit.
// ----------------------------------------------------------------------------
module abec_sweep_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  abec_pkg::quartet_t in_data_i,
  input  abec_pkg::limit_t   limit_i,
  input  logic               out_free_i,
  input  abec_pkg::eval_t    eval_i,
  output abec_pkg::issue_t   issue_o,
  output abec_pkg::ctrl_t    ctrl_o
);

  abec_pkg::state_e state_q, state_d;
  abec_pkg::word_t  x_q, x_d;
  abec_pkg::word_t  y_q, y_d;
  abec_pkg::word_t  lim_q;
  abec_pkg::diff_t  diff_q;
  logic             accept;
  logic             last;

  assign accept = in_valid_i & in_ready_o;
  assign last   = (x_q == lim_q) && (y_q == lim_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= abec_pkg::S_IDLE;
      x_q     <= '0;
      y_q     <= '0;
    end else begin
      state_q <= state_d;
      x_q     <= x_d;
      y_q     <= y_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lim_q              <= abec_pkg::eff_limit(limit_i);
      diff_q.alpha       <= abec_pkg::word_t'(in_data_i.alpha);
      diff_q.alpha_prime <= abec_pkg::word_t'(in_data_i.alpha_prime);
      diff_q.beta        <= abec_pkg::word_t'(in_data_i.beta);
      diff_q.beta_prime  <= abec_pkg::word_t'(in_data_i.beta_prime);
    end
  end

  always_comb begin
    state_d      = state_q;
    x_d          = x_q;
    y_d          = y_q;
    in_ready_o   = 1'b0;
    issue_o      = '{valid: 1'b0, last: last, x: x_q, y: y_q, diff: diff_q};
    ctrl_o       = '{start: 1'b0, load: 1'b0};
    unique case (state_q)
      abec_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.start = 1'b1;
          x_d          = '0;
          y_d          = '0;
          state_d      = abec_pkg::S_SWEEP;
        end
      end
      abec_pkg::S_SWEEP: begin
        issue_o.valid = 1'b1;
        if (last) begin
          state_d = abec_pkg::S_DRAIN;
        end else if (y_q == lim_q) begin
          y_d = '0;
          x_d = x_q + 1'b1;
        end else begin
          y_d = y_q + 1'b1;
        end
      end
      abec_pkg::S_DRAIN: begin
        if (eval_i.valid && eval_i.last) begin
          state_d = abec_pkg::S_DONE;
        end
      end
      abec_pkg::S_DONE: begin
        if (out_free_i) begin
          ctrl_o.load = 1'b1;
          state_d     = abec_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = abec_pkg::S_IDLE;
      end
    endcase
  end

  a_sweep_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == abec_pkg::S_SWEEP) |-> (x_q <= lim_q) && (y_q <= lim_q))
    else $error("sweep counter beyond limit");

  a_idle_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !issue_o.valid)
    else $error("pair issued while idle");

  a_drain_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == abec_pkg::S_DRAIN) |-> eval_i.valid && eval_i.last)
    else $error("last pair missing at drain");

  a_load_needs_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load |-> out_free_i && (state_q == abec_pkg::S_DONE))
    else $error("result load while output busy");

endmodule
